/* rtl/gbts_pkg.sv */
// shared types, constants and helpers for the gap buffer text store
package gbts_pkg;

  // store geometry
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int IDX_W    = ADDR_W + 1;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command codes on the request port
  localparam logic [2:0] CMD_INSERT    = 3'd0;
  localparam logic [2:0] CMD_BACKSPACE = 3'd1;
  localparam logic [2:0] CMD_LEFT      = 3'd2;
  localparam logic [2:0] CMD_RIGHT     = 3'd3;
  localparam logic [2:0] CMD_MOVE      = 3'd4;
  localparam logic [2:0] CMD_END       = 3'd5;

  // status codes on the result port
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_PAST_END = 2'd2;

  // request and result payloads
  typedef struct packed {
    logic [2:0]       command;
    logic [7:0]       char_in;
    logic [IDX_W-1:0] position;
  } gbts_request_t;

  typedef struct packed {
    logic [IDX_W-1:0] cursor;
    logic [IDX_W-1:0] text_length;
    logic [1:0]       status;
  } gbts_result_t;

  // decoded operation held in the queue
  typedef enum logic [2:0] {
    OP_INSERT,
    OP_BACKSPACE,
    OP_LEFT,
    OP_RIGHT,
    OP_MOVE,
    OP_END,
    OP_NONE
  } gbts_op_t;

  typedef struct packed {
    gbts_op_t         op;
    logic [7:0]       char_in;
    logic [IDX_W-1:0] position;
  } gbts_entry_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic        valid;
    gbts_entry_t entry;
  } gbts_head_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MOVE,
    BK_COPY
  } gbts_back_state_t;

  // characters held: cursor plus capacity minus gap end
  function automatic logic [IDX_W-1:0] held_length(input logic [IDX_W-1:0] cursor,
                                                   input logic [IDX_W-1:0] gap_end);
    logic [IDX_W:0] sum;
    sum = {1'b0, cursor} + (IDX_W+1)'(CAPACITY) - {1'b0, gap_end};
    return sum[IDX_W-1:0];
  endfunction

endpackage

/* rtl/gbts_front.sv */
// front end: command decode and a short queue toward the back end
module gbts_front
  import gbts_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  gbts_request_t request,
  input  logic          pop,
  output gbts_head_t    head
);

  gbts_entry_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  gbts_entry_t       decoded;

  // classify the incoming command
  always_comb begin
    decoded.char_in  = request.char_in;
    decoded.position = request.position;
    case (request.command)
      CMD_INSERT:    decoded.op = OP_INSERT;
      CMD_BACKSPACE: decoded.op = OP_BACKSPACE;
      CMD_LEFT:      decoded.op = OP_LEFT;
      CMD_RIGHT:     decoded.op = OP_RIGHT;
      CMD_MOVE:      decoded.op = OP_MOVE;
      CMD_END:       decoded.op = OP_END;
      default:       decoded.op = OP_NONE;
    endcase
  end

  // transfer in when the queue has room
  assign busy = (count == QCNT_W'(QUEUE_DEPTH));
  assign push = start && !busy;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // head of queue
  assign head.valid = (count != '0);
  assign head.entry = entries[rd_ptr];

endmodule

/* rtl/gbts_back.sv */
// back end: executes commands on the text memory and reports results
module gbts_back
  import gbts_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  gbts_head_t   head,
  output logic         pop,
  output logic         done,
  output gbts_result_t result
);

  logic [7:0]       mem [CAPACITY];
  logic [7:0]       rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             wr_en;

  gbts_back_state_t state, state_next;
  logic [IDX_W-1:0] cursor, cursor_next;
  logic [IDX_W-1:0] gap_end, gap_end_next;
  logic [IDX_W-1:0] target, target_next;
  logic [1:0]       status, status_next;
  logic             done_next;
  logic [IDX_W-1:0] length;
  logic             full;
  logic             at_start;
  logic             at_end;

  assign length   = held_length(cursor, gap_end);
  assign full     = (cursor >= gap_end);
  assign at_start = (cursor == '0);
  assign at_end   = (gap_end == IDX_W'(CAPACITY));

  // text memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (head.valid) begin
          case (head.entry.op)
            OP_LEFT, OP_RIGHT, OP_END: state_next = BK_MOVE;
            OP_MOVE: state_next = (head.entry.position > length) ? BK_IDLE : BK_MOVE;
            default: state_next = BK_IDLE;
          endcase
        end
      end
      BK_MOVE: state_next = (cursor == target) ? BK_IDLE : BK_COPY;
      BK_COPY: state_next = BK_MOVE;
      default: state_next = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop          = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = cursor[ADDR_W-1:0];
    wr_data      = head.entry.char_in;
    rd_addr      = gap_end[ADDR_W-1:0];
    cursor_next  = cursor;
    gap_end_next = gap_end;
    target_next  = target;
    status_next  = status;
    done_next    = 1'b0;
    case (state)
      BK_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.entry.op)
            OP_INSERT: begin
              done_next = 1'b1;
              if (full) begin
                status_next = ST_FULL;
              end else begin
                status_next = ST_DONE;
                wr_en       = 1'b1;
                cursor_next = cursor + IDX_W'(1);
              end
            end
            OP_BACKSPACE: begin
              done_next   = 1'b1;
              status_next = ST_DONE;
              if (!at_start) begin
                cursor_next = cursor - IDX_W'(1);
              end
            end
            OP_LEFT: begin
              target_next = at_start ? cursor : cursor - IDX_W'(1);
            end
            OP_RIGHT: begin
              target_next = at_end ? cursor : cursor + IDX_W'(1);
            end
            OP_MOVE: begin
              if (head.entry.position > length) begin
                done_next   = 1'b1;
                status_next = ST_PAST_END;
              end else begin
                target_next = head.entry.position;
              end
            end
            OP_END: begin
              target_next = length;
            end
            default: begin
              done_next   = 1'b1;
              status_next = ST_DONE;
            end
          endcase
        end
      end
      BK_MOVE: begin
        // fetch the character that crosses the gap
        if (cursor == target) begin
          done_next   = 1'b1;
          status_next = ST_DONE;
        end else if (cursor < target) begin
          rd_addr = gap_end[ADDR_W-1:0];
        end else begin
          rd_addr = ADDR_W'(cursor - IDX_W'(1));
        end
      end
      BK_COPY: begin
        // store it on the other side and shift both edges
        wr_en   = 1'b1;
        wr_data = rd_data;
        if (cursor < target) begin
          wr_addr      = cursor[ADDR_W-1:0];
          cursor_next  = cursor + IDX_W'(1);
          gap_end_next = gap_end + IDX_W'(1);
        end else begin
          wr_addr      = ADDR_W'(gap_end - IDX_W'(1));
          cursor_next  = cursor - IDX_W'(1);
          gap_end_next = gap_end - IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // control and index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      cursor  <= '0;
      gap_end <= IDX_W'(CAPACITY);
      status  <= ST_DONE;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      cursor  <= cursor_next;
      gap_end <= gap_end_next;
      status  <= status_next;
      done    <= done_next;
    end
  end

  // move target
  always_ff @(posedge clk) begin
    target <= target_next;
  end

  // result transfer
  assign result.cursor      = cursor;
  assign result.text_length = length;
  assign result.status      = status;

endmodule

/* rtl/gap_buffer_text_store.sv */
// Gap buffer text store of CAPACITY bytes with an edit cursor. A command is taken when start
// is high and busy is low; a two-entry queue lets up to two commands wait while the back end
// works. Every command gives one result on result, marked by done for one cycle; results
// cannot be held off. Insert, backspace, an ignored move and unused codes are finished in the
// idle state when they reach the head of the queue and report through the done register.
// Left, right, move to position and move to end pass each character across the gap in turn:
// the move state reads it from the registered-read text memory, and the copy state writes it.
module gap_buffer_text_store
  import gbts_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  gbts_request_t request,
  output logic          done,
  output gbts_result_t  result
);

  gbts_head_t head;
  logic       pop;

  gbts_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .pop     (pop),
    .head    (head)
  );

  gbts_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

  // the back end only takes from a queue that holds something
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from empty command queue");

  // the cursor never passes the end of the text
  a_cursor_in_text: assert property (@(posedge clk) disable iff (rst)
    result.cursor <= result.text_length)
    else $error("cursor beyond text length");

  // a transfer in leaves the queue holding something on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> head.valid)
    else $error("accepted command missing from queue");

endmodule
